/* design/llrc_pkg.sv */
package llrc_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int SLOT_BYTES  = 256;
   localparam int CHUNK_LIMIT = 512;

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int POS_W   = $clog2(SLOT_BYTES);
   localparam int ADDR_W  = SLOT_W + POS_W;
   localparam int HELD_W  = SLOT_W + 1;
   localparam int CHUNK_W = $clog2(CHUNK_LIMIT);
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int WANT_W  = 7;

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

   localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR = 8'd13;

   localparam logic [WANT_W-1:0] WANT_MAX   = 7'd64;
   localparam logic [WANT_W-1:0] WANT_RESET = 7'd10;

   localparam logic [CHUNK_W-1:0] STORE_MAX   = CHUNK_W'(SLOT_BYTES - 1);
   localparam logic [CHUNK_W-1:0] CHUNK_SPLIT = CHUNK_W'(CHUNK_LIMIT - 1);
   localparam logic [HELD_W-1:0]  RING_FULL   = HELD_W'(SLOT_COUNT);

   typedef struct packed {
      logic data_en;
      logic end_en;
      logic setup_en;
      logic rd_issue;
      logic rd_step;
   } cmd_type;

   typedef struct packed {
      logic rsp_full;
   } status_type;

endpackage

/* design/llrc_ctrl.sv */
module llrc_ctrl
   import llrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   input  logic              rsp_stall,
   input  status_type        status,
   output logic              req_stall,
   output cmd_type           cmd
);

   typedef enum logic [1:0] {
      ST_CAPTURE,
      ST_SETUP,
      ST_REPLAY,
      ST_FETCH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_comb begin
      case (state_ff)
         ST_CAPTURE: req_stall = 1'b0;
         ST_REPLAY:  req_stall = status.rsp_full && rsp_stall;
         default:    req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CAPTURE: begin
            cmd.data_en = accept && (req_kind == KIND_DATA);
            cmd.end_en  = accept && (req_kind == KIND_END);
            if (cmd.end_en) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup_en = 1'b1;
            state_in     = ST_REPLAY;
         end
         ST_REPLAY: begin
            cmd.rd_issue = accept && (req_kind == KIND_READ);
            if (cmd.rd_issue) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.rd_step = 1'b1;
            state_in    = ST_REPLAY;
         end
         default: begin
            state_in = ST_CAPTURE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CAPTURE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/llrc_datapath.sv */
module llrc_datapath
   import llrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              csr_wr_en,
   input  logic [WANT_W-1:0] csr_lines_wanted,
   input  logic              rsp_stall,
   output status_type        status,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_line_end,
   output logic              rsp_done_res
);

   logic [BYTE_W-1:0] store_mem [SLOT_COUNT*SLOT_BYTES];
   logic [POS_W-1:0]  length_mem [SLOT_COUNT];

   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [HELD_W-1:0]  line_ff, line_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [WANT_W-1:0]  wanted_ff;

   logic [BYTE_W-1:0]  rd_byte_ff;
   logic [POS_W-1:0]   rd_len_ff;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               line_end_ff;
   logic               done_ff;

   logic               is_cr, is_lf, is_text;
   logic [CHUNK_W-1:0] chunk_inc;
   logic               ring_full;
   logic [SLOT_W-1:0]  target;
   logic               store_we;
   logic               commit;
   logic [CHUNK_W-1:0] commit_count;
   logic [POS_W-1:0]   commit_len;
   logic [WANT_W-1:0]  want;
   logic [SLOT_W-1:0]  rd_slot;

   assign is_cr     = (req_in_byte == CH_CR);
   assign is_lf     = (req_in_byte == CH_LF);
   assign is_text   = cmd.data_en && !is_cr && !is_lf;
   assign chunk_inc = chunk_ff + CHUNK_W'(1);
   assign ring_full = (held_ff == RING_FULL);
   assign target    = ring_full ? oldest_ff : oldest_ff + held_ff[SLOT_W-1:0];
   assign store_we  = is_text && (chunk_ff < STORE_MAX);

   assign commit = (cmd.end_en && (chunk_ff != '0))
                || (cmd.data_en && is_lf)
                || (is_text && (chunk_inc == CHUNK_SPLIT));

   assign commit_count = is_text ? chunk_inc : chunk_ff;
   assign commit_len   = (commit_count > STORE_MAX) ? STORE_MAX[POS_W-1:0]
                                                    : commit_count[POS_W-1:0];

   assign rd_slot = oldest_ff + line_ff[SLOT_W-1:0];

   // clamp the wanted count to the range and to what the ring holds
   always_comb begin
      want = wanted_ff;
      if (want == '0) begin
         want = WANT_W'(1);
      end else if (want > WANT_MAX) begin
         want = WANT_MAX;
      end
      if (HELD_W'(want) > held_ff) begin
         want = WANT_W'(held_ff);
      end
   end

   always_comb begin
      oldest_in = oldest_ff;
      held_in   = held_ff;
      chunk_in  = chunk_ff;
      line_in   = line_ff;
      pos_in    = pos_ff;
      if (commit) begin
         chunk_in = '0;
         if (ring_full) begin
            oldest_in = oldest_ff + SLOT_W'(1);
         end else begin
            held_in = held_ff + HELD_W'(1);
         end
      end else if (is_text) begin
         chunk_in = chunk_inc;
      end
      if (cmd.setup_en) begin
         line_in = held_ff - HELD_W'(want);
         pos_in  = '0;
      end
      if (cmd.rd_step && (line_ff < held_ff)) begin
         if (pos_ff < rd_len_ff) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in  = '0;
            line_in = line_ff + HELD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[{target, chunk_ff[POS_W-1:0]}] <= req_in_byte;
      end
      if (commit) begin
         length_mem[target] <= commit_len;
      end
      if (cmd.rd_issue) begin
         rd_byte_ff <= store_mem[{rd_slot, pos_ff}];
         rd_len_ff  <= length_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         held_ff      <= '0;
         chunk_ff     <= '0;
         line_ff      <= '0;
         pos_ff       <= '0;
         wanted_ff    <= WANT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
         chunk_ff  <= chunk_in;
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         if (csr_wr_en) begin
            wanted_ff <= csr_lines_wanted;
         end
         if (cmd.rd_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_step) begin
         if (line_ff >= held_ff) begin
            out_byte_ff <= '0;
            line_end_ff <= 1'b0;
            done_ff     <= 1'b1;
         end else if (pos_ff < rd_len_ff) begin
            out_byte_ff <= rd_byte_ff;
            line_end_ff <= 1'b0;
            done_ff     <= 1'b0;
         end else begin
            out_byte_ff <= CH_LF;
            line_end_ff <= 1'b1;
            done_ff     <= 1'b0;
         end
      end
   end

   assign status.rsp_full = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_line_end    = line_end_ff;
   assign rsp_done_res    = done_ff;

endmodule

/* design/last_lines_ring_capture.sv */
// Keeps the newest 64 lines of a byte stream in a ring of 256-byte slots and
// replays them after the end item. While capturing, one data item is taken
// every cycle (one write to the line memory plus counter updates). The end
// item is followed by a replay setup state during which no item is taken.
// Each read item then uses the registered read of the line memory and the
// length table: the item is accepted, the memories are read, and the result
// is loaded into the output register on the next cycle. A new read is taken
// while the previous result is being collected, unless the output is stalled.
// Data and end items after the end, reads before the end and kind 3 are taken
// and dropped. The lines_wanted register is sampled in the setup state.
module last_lines_ring_capture
   import llrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_line_end,
   output logic              rsp_done_res,
   input  logic              csr_wr_en,
   input  logic [WANT_W-1:0] csr_lines_wanted
);

   cmd_type    cmd;
   status_type status;

   llrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   llrc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_in_byte      (req_in_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_lines_wanted (csr_lines_wanted),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_line_end     (rsp_line_end),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

/* design/llrc_checker.sv */
module llrc_checker
   import llrc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [KIND_W-1:0] req_kind,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_line_end,
   input logic              rsp_done_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_line_end) && $stable(rsp_done_res))
      else $error("stalled item changed");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> (rsp_out_byte == '0) && !rsp_line_end)
      else $error("done item carries data");

   a_line_end_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> (rsp_out_byte == CH_LF))
      else $error("line end without lf");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && (req_kind == KIND_READ), 2))
      else $error("result without a read item");

endmodule

bind last_lines_ring_capture llrc_checker u_llrc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_kind     (req_kind),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_line_end (rsp_line_end),
   .rsp_done_res (rsp_done_res)
);
